/* src/ocvh_pkg.sv */
// Shared types, constants and helpers for the online polygon convex hull core.
// No dependencies; used by ocvh_front, ocvh_back and the top level.
`default_nettype none

package ocvh_pkg;

  localparam int unsigned RING_DEPTH = 1024;
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned IDX_BITS   = 10;
  localparam int unsigned SIZE_BITS  = 11;
  localparam int unsigned PTR_BITS   = $clog2(RING_DEPTH);
  localparam int unsigned CNT_BITS   = $clog2(RING_DEPTH + 1);
  localparam int unsigned PT_BITS    = 2 * COORD_BITS;
  localparam int unsigned DIFF_BITS  = COORD_BITS + 1;
  localparam int unsigned PROD_BITS  = 2 * DIFF_BITS;
  localparam int unsigned CMP_BITS   = (IDX_BITS > CNT_BITS) ? IDX_BITS : CNT_BITS;
  localparam int unsigned SUM_BITS   = ((PTR_BITS > IDX_BITS) ? PTR_BITS : IDX_BITS) + 1;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [IDX_BITS-1:0]   idx;
  } item_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0]         hull_size;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         point_kept;
    logic [1:0]                   status;
  } result_t;

  function automatic logic [PTR_BITS-1:0] ring_next(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_BITS-1:0] ring_prev(input logic [PTR_BITS-1:0] p);
    return (p == '0) ? PTR_BITS'(RING_DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pt_x(input logic [PT_BITS-1:0] p);
    return p[PT_BITS-1 -: COORD_BITS];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pt_y(input logic [PT_BITS-1:0] p);
    return p[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [DIFF_BITS-1:0] coord_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [DIFF_BITS-1:0] ae;
    logic signed [DIFF_BITS-1:0] be;
    ae = DIFF_BITS'(a);
    be = DIFF_BITS'(b);
    return ae - be;
  endfunction

endpackage

`default_nettype wire

/* src/ocvh_front.sv */
// Front end: accepts command words, classifies them and queues them (2 deep).
// Depends on ocvh_pkg.
`default_nettype none

module ocvh_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           in_command,
  input  wire logic signed [ocvh_pkg::COORD_BITS-1:0] in_point_x,
  input  wire logic signed [ocvh_pkg::COORD_BITS-1:0] in_point_y,
  input  wire logic [ocvh_pkg::IDX_BITS-1:0]        in_read_index,
  output logic                                      item_valid,
  input  wire logic                                 item_ready,
  output ocvh_pkg::item_t                           item
);

  ocvh_pkg::item_t q_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;
  logic            push;
  logic            pop;
  ocvh_pkg::item_t cls;

  always_comb begin
    cls.x   = in_point_x;
    cls.y   = in_point_y;
    cls.idx = in_read_index;
    case (in_command)
      ocvh_pkg::CMD_ADD:   cls.op = ocvh_pkg::OP_ADD;
      ocvh_pkg::CMD_READ:  cls.op = ocvh_pkg::OP_READ;
      ocvh_pkg::CMD_CLEAR: cls.op = ocvh_pkg::OP_CLEAR;
      default:             cls.op = ocvh_pkg::OP_NOP;
    endcase
  end

  assign in_ready   = (cnt_r != 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rd_ptr_r];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

/* src/ocvh_back.sv */
// Back end: hull ring memory, orientation test unit and command sequencer,
// plus the result register. Depends on ocvh_pkg.
`default_nettype none

module ocvh_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_valid,
  output logic                 item_ready,
  input  wire ocvh_pkg::item_t item,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output ocvh_pkg::result_t    res
);

  localparam int unsigned PW = ocvh_pkg::PTR_BITS;
  localparam int unsigned NW = ocvh_pkg::CNT_BITS;
  localparam int unsigned DW = ocvh_pkg::PT_BITS;
  localparam int unsigned CW = ocvh_pkg::CMP_BITS;
  localparam int unsigned SW = ocvh_pkg::SUM_BITS;
  localparam int unsigned XW = ocvh_pkg::PROD_BITS;

  typedef enum logic [15:0] {
    S_IDLE       = 16'h0001,
    S_SEED_MUL   = 16'h0002,
    S_SEED_WR    = 16'h0004,
    S_READ_RD    = 16'h0008,
    S_READ_DAT   = 16'h0010,
    S_LOOPF_HEAD = 16'h0020,
    S_LOOPB_HEAD = 16'h0040,
    S_TEST_RD    = 16'h0080,
    S_TEST_MUL   = 16'h0100,
    S_TEST_CMP   = 16'h0200,
    S_F_EXIT     = 16'h0400,
    S_B_EXIT     = 16'h0800,
    S_WR_FRONT   = 16'h1000,
    S_WR_BACK    = 16'h2000,
    S_DONE       = 16'h4000,
    S_SPARE      = 16'h8000
  } state_t;

  typedef enum logic [3:0] {
    STEP_CHK_F  = 4'b0001,
    STEP_CHK_B  = 4'b0010,
    STEP_LOOP_F = 4'b0100,
    STEP_LOOP_B = 4'b1000
  } step_t;

  state_t state_r;
  step_t  step_r;

  logic [DW-1:0] ring_mem [ocvh_pkg::RING_DEPTH];
  logic [DW-1:0] rdata_r;
  logic [PW-1:0] rd_addr;
  logic          we;
  logic [PW-1:0] waddr;
  logic [DW-1:0] wdata;

  logic [PW-1:0] f_r, b_r, fw_r, bw_r;
  logic [NW-1:0] n_r, nw_r;
  logic [1:0]    ps_r;
  logic [DW-1:0] top_r, seed0_r, seed1_r, p_r, fpt_r, bpt_r, memq_r;
  logic [ocvh_pkg::IDX_BITS-1:0] idx_r;
  logic [1:0]    wcnt_r;
  logic signed [XW-1:0] prod1_r, prod2_r;
  logic          turn_ok;

  logic                 pk_r;
  logic [1:0]           pst_r;
  logic [DW-1:0]        pv_r;
  logic                 res_valid_r;
  ocvh_pkg::result_t    res_r;

  logic [DW-1:0] op_a, op_b, op_c;
  logic [SW-1:0] rsum;
  logic [PW-1:0] raddr_sum;

  assign item_ready = (state_r == S_IDLE);
  assign res_valid  = res_valid_r;
  assign res        = res_r;
  assign turn_ok    = (prod1_r >= prod2_r);

  always_comb begin
    rsum = SW'(f_r) + SW'(idx_r);
    if (rsum >= SW'(ocvh_pkg::RING_DEPTH)) begin
      rsum = rsum - SW'(ocvh_pkg::RING_DEPTH);
    end
    raddr_sum = rsum[PW-1:0];
  end

  always_comb begin
    if (state_r == S_READ_RD) begin
      rd_addr = raddr_sum;
    end else if (step_r == STEP_CHK_B || step_r == STEP_LOOP_B) begin
      rd_addr = ocvh_pkg::ring_prev(bw_r);
    end else begin
      rd_addr = ocvh_pkg::ring_next(fw_r);
    end
  end

  // orientation operands: cross(a, b, c) >= 0
  always_comb begin
    op_c = p_r;
    if (state_r == S_SEED_MUL) begin
      op_a = seed0_r;
      op_b = seed1_r;
    end else if (step_r == STEP_CHK_B || step_r == STEP_LOOP_B) begin
      op_a = bpt_r;
      op_b = rdata_r;
    end else begin
      op_a = rdata_r;
      op_b = fpt_r;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = PW'(wcnt_r);
    wdata = p_r;
    case (state_r)
      S_SEED_WR: begin
        we = 1'b1;
        case (wcnt_r)
          2'd1:    wdata = turn_ok ? seed1_r : seed0_r;
          2'd2:    wdata = turn_ok ? seed0_r : seed1_r;
          default: wdata = p_r;
        endcase
      end
      S_WR_FRONT: begin
        we    = 1'b1;
        waddr = ocvh_pkg::ring_prev(fw_r);
      end
      S_WR_BACK: begin
        we    = 1'b1;
        waddr = ocvh_pkg::ring_next(bw_r);
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      ring_mem[waddr] <= wdata;
    end
    rdata_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SEED_MUL || state_r == S_TEST_MUL) begin
      prod1_r <= ocvh_pkg::coord_diff(ocvh_pkg::pt_x(op_b), ocvh_pkg::pt_x(op_a))
               * ocvh_pkg::coord_diff(ocvh_pkg::pt_y(op_c), ocvh_pkg::pt_y(op_a));
      prod2_r <= ocvh_pkg::coord_diff(ocvh_pkg::pt_x(op_c), ocvh_pkg::pt_x(op_a))
               * ocvh_pkg::coord_diff(ocvh_pkg::pt_y(op_b), ocvh_pkg::pt_y(op_a));
      memq_r  <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_CHK_F;
      f_r         <= '0;
      b_r         <= '0;
      n_r         <= '0;
      ps_r        <= 2'd0;
      wcnt_r      <= 2'd0;
      res_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!res_valid_r || res_ready)) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (item_valid) begin
            p_r   <= {item.x, item.y};
            idx_r <= item.idx;
            pv_r  <= '0;
            pk_r  <= (item.op == ocvh_pkg::OP_ADD) && (ps_r < 2'd2);
            pst_r <= (item.op == ocvh_pkg::OP_READ && CW'(item.idx) >= CW'(n_r)) ?
                     ocvh_pkg::ST_RANGE : ocvh_pkg::ST_OK;
            case (item.op)
              ocvh_pkg::OP_ADD: begin
                if (ps_r == 2'd0 || ps_r == 2'd1) begin
                  if (ps_r == 2'd0) begin
                    seed0_r <= {item.x, item.y};
                  end else begin
                    seed1_r <= {item.x, item.y};
                  end
                  ps_r    <= ps_r + 2'd1;
                  state_r <= S_DONE;
                end else if (ps_r == 2'd2) begin
                  state_r <= S_SEED_MUL;
                end else begin
                  fw_r    <= f_r;
                  bw_r    <= b_r;
                  nw_r    <= n_r;
                  fpt_r   <= top_r;
                  bpt_r   <= top_r;
                  step_r  <= STEP_CHK_F;
                  state_r <= S_TEST_RD;
                end
              end
              ocvh_pkg::OP_READ: begin
                if (CW'(item.idx) >= CW'(n_r)) begin
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_READ_RD;
                end
              end
              ocvh_pkg::OP_CLEAR: begin
                f_r     <= '0;
                b_r     <= '0;
                n_r     <= '0;
                ps_r    <= 2'd0;
                state_r <= S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_SEED_MUL: begin
          wcnt_r  <= 2'd0;
          state_r <= S_SEED_WR;
        end
        S_SEED_WR: begin
          wcnt_r <= wcnt_r + 2'd1;
          if (wcnt_r == 2'd3) begin
            f_r     <= '0;
            b_r     <= PW'(3);
            n_r     <= NW'(4);
            ps_r    <= 2'd3;
            top_r   <= p_r;
            pk_r    <= 1'b1;
            state_r <= S_DONE;
          end
        end
        S_READ_RD:  state_r <= S_READ_DAT;
        S_READ_DAT: begin
          pv_r    <= rdata_r;
          state_r <= S_DONE;
        end
        S_TEST_RD:  state_r <= S_TEST_MUL;
        S_TEST_MUL: state_r <= S_TEST_CMP;
        S_TEST_CMP: begin
          case (step_r)
            STEP_CHK_F: begin
              if (turn_ok) begin
                step_r  <= STEP_CHK_B;
                state_r <= S_TEST_RD;
              end else begin
                state_r <= S_LOOPF_HEAD;
              end
            end
            STEP_CHK_B: begin
              // inside both end wedges: point dropped
              state_r <= turn_ok ? S_DONE : S_LOOPF_HEAD;
            end
            STEP_LOOP_F: begin
              if (turn_ok) begin
                state_r <= S_F_EXIT;
              end else begin
                fw_r    <= ocvh_pkg::ring_next(fw_r);
                fpt_r   <= memq_r;
                nw_r    <= nw_r - 1'b1;
                state_r <= S_LOOPF_HEAD;
              end
            end
            default: begin
              if (turn_ok) begin
                state_r <= S_B_EXIT;
              end else begin
                bw_r    <= ocvh_pkg::ring_prev(bw_r);
                bpt_r   <= memq_r;
                nw_r    <= nw_r - 1'b1;
                state_r <= S_LOOPB_HEAD;
              end
            end
          endcase
        end
        S_LOOPF_HEAD: begin
          if (nw_r > NW'(2)) begin
            step_r  <= STEP_LOOP_F;
            state_r <= S_TEST_RD;
          end else begin
            state_r <= S_F_EXIT;
          end
        end
        S_F_EXIT: begin
          if (nw_r >= NW'(ocvh_pkg::RING_DEPTH)) begin
            pst_r   <= ocvh_pkg::ST_OVERFLOW;
            state_r <= S_DONE;
          end else begin
            // front push is deferred until the back side is known to fit
            nw_r    <= nw_r + 1'b1;
            state_r <= S_LOOPB_HEAD;
          end
        end
        S_LOOPB_HEAD: begin
          if (nw_r > NW'(2)) begin
            step_r  <= STEP_LOOP_B;
            state_r <= S_TEST_RD;
          end else begin
            state_r <= S_B_EXIT;
          end
        end
        S_B_EXIT: begin
          if (nw_r >= NW'(ocvh_pkg::RING_DEPTH)) begin
            pst_r   <= ocvh_pkg::ST_OVERFLOW;
            state_r <= S_DONE;
          end else begin
            state_r <= S_WR_FRONT;
          end
        end
        S_WR_FRONT: state_r <= S_WR_BACK;
        S_WR_BACK: begin
          f_r     <= ocvh_pkg::ring_prev(fw_r);
          b_r     <= ocvh_pkg::ring_next(bw_r);
          n_r     <= nw_r + 1'b1;
          top_r   <= p_r;
          pk_r    <= 1'b1;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid_r || res_ready) begin
            res_r.hull_size <= ocvh_pkg::SIZE_BITS'(n_r);
            res_r.vertex_x  <= ocvh_pkg::pt_x(pv_r);
            res_r.vertex_y  <= ocvh_pkg::pt_y(pv_r);
            res_r.point_kept <= pk_r;
            res_r.status    <= pst_r;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/online_polygon_convex_hull_core.sv */
// Online convex hull of a simple polygon: command input channel, result
// output channel. Top level over ocvh_front and ocvh_back; uses ocvh_pkg.
//
// Usage: each input word carries a command (add vertex, read hull entry,
// clear) with its operands; every accepted word yields exactly one result
// word (hull size, read vertex, kept flag, status), in order.
// Both channels are valid/ready. A 2-deep queue in the front end feeds
// the sequencer, and the result sits in an output register, so
// the input side keeps accepting while a result waits to be taken.
// Steps per word: a read does a ring read and then takes the data;
// clear, unused codes and seed adds go straight to the result; the third
// vertex runs one orientation test and the seed ring writes. A later add
// runs the end tests and, when not dropped, the front and back pop loops
// with one test per loop step, then the exits and the two ring writes;
// each test is a ring read, a multiply and a compare. Throughput is one
// word at a time through the sequencer, set by the single ring read port
// and the shared orientation unit.
// Reset empties the queue and the hull; ring contents are not cleared.
// A stalled receiver holds the result; the sequencer then waits with the
// next result and the queue fills, after which in_ready drops.
`default_nettype none

module online_polygon_convex_hull_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [1:0]                             in_command,
  input  wire logic signed [ocvh_pkg::COORD_BITS-1:0] in_point_x,
  input  wire logic signed [ocvh_pkg::COORD_BITS-1:0] in_point_y,
  input  wire logic [ocvh_pkg::IDX_BITS-1:0]          in_read_index,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [ocvh_pkg::SIZE_BITS-1:0]              out_hull_size,
  output logic signed [ocvh_pkg::COORD_BITS-1:0]      out_vertex_x,
  output logic signed [ocvh_pkg::COORD_BITS-1:0]      out_vertex_y,
  output logic                                        out_point_kept,
  output logic [1:0]                                  out_status
);

  logic              item_valid;
  logic              item_ready;
  ocvh_pkg::item_t   item;
  ocvh_pkg::result_t res;

  ocvh_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_read_index (in_read_index),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item)
  );

  ocvh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign out_hull_size  = res.hull_size;
  assign out_vertex_x   = res.vertex_x;
  assign out_vertex_y   = res.vertex_y;
  assign out_point_kept = res.point_kept;
  assign out_status     = res.status;

  // kept points never carry an error
  a_kept_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_kept |-> out_status == ocvh_pkg::ST_OK)
    else $error("kept point reported with error status");

  // only a successful read returns a vertex
  a_vertex_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ocvh_pkg::ST_OK |-> out_vertex_x == '0 && out_vertex_y == '0)
    else $error("vertex data on failed word");

  // the ring holds either nothing or at least four entries (ends doubled)
  a_hull_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hull_size == '0 || out_hull_size >= ocvh_pkg::SIZE_BITS'(4))
    else $error("impossible hull size");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

/* sim/tb_online_polygon_convex_hull_core.sv */
// Testbench for online_polygon_convex_hull_core: drives polygon vertices, reads and
// clears over valid/ready and checks every result word against a local hull tracker.
// Depends on ocvh_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_online_polygon_convex_hull_core;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [ocvh_pkg::COORD_BITS-1:0] x;
    logic signed [ocvh_pkg::COORD_BITS-1:0] y;
  } vtx_t;

  // Tracks the hull ring and queues the result each accepted word must produce.
  class hull_tracker;
    vtx_t              ring [ocvh_pkg::RING_DEPTH];
    vtx_t              seeds [2];
    int                head_ptr;
    int                tail_ptr;
    int                live;
    int                seeded;
    ocvh_pkg::result_t pending_results [$];
    int                errors;

    function new();
      head_ptr = 0;
      tail_ptr = 0;
      live = 0;
      seeded = 0;
      errors = 0;
    endfunction

    function int fwd(int i);
      return (i + 1 >= ocvh_pkg::RING_DEPTH) ? 0 : i + 1;
    endfunction

    function int bwd(int i);
      return (i == 0) ? ocvh_pkg::RING_DEPTH - 1 : i - 1;
    endfunction

    // cross(a,b,c) >= 0
    function bit turn_ok(vtx_t a, vtx_t b, vtx_t c);
      longint cr;
      cr = (longint'(b.x) - longint'(a.x)) * (longint'(c.y) - longint'(a.y)) -
           (longint'(c.x) - longint'(a.x)) * (longint'(b.y) - longint'(a.y));
      return cr >= 0;
    endfunction

    // Returns status; kept set when the vertex entered the hull.
    function logic [1:0] insert_vertex(vtx_t p, output bit kept);
      int   f, b, n, slot;
      vtx_t saved;
      kept = 0;
      f = head_ptr;
      b = tail_ptr;
      n = live;
      if (turn_ok(ring[fwd(f)], ring[f], p) && turn_ok(ring[b], ring[bwd(b)], p))
        return ocvh_pkg::ST_OK;
      while (n > 2 && !turn_ok(ring[fwd(f)], ring[f], p)) begin
        f = fwd(f);
        n--;
      end
      if (n >= ocvh_pkg::RING_DEPTH) return ocvh_pkg::ST_OVERFLOW;
      slot = bwd(f);
      saved = ring[slot];
      ring[slot] = p;
      f = slot;
      n++;
      while (n > 2 && !turn_ok(ring[b], ring[bwd(b)], p)) begin
        b = bwd(b);
        n--;
      end
      if (n >= ocvh_pkg::RING_DEPTH) begin
        ring[slot] = saved;
        return ocvh_pkg::ST_OVERFLOW;
      end
      b = fwd(b);
      ring[b] = p;
      n++;
      head_ptr = f;
      tail_ptr = b;
      live = n;
      kept = 1;
      return ocvh_pkg::ST_OK;
    endfunction

    function ocvh_pkg::result_t advance_hull(ocvh_pkg::op_t op, vtx_t p,
                                             logic [ocvh_pkg::IDX_BITS-1:0] idx);
      ocvh_pkg::result_t r;
      bit                kept;
      int                pos;
      r = '0;
      kept = 0;
      case (op)
        ocvh_pkg::OP_ADD: begin
          if (seeded < 2) begin
            seeds[seeded] = p;
            seeded++;
            kept = 1;
          end else if (seeded == 2) begin
            ring[0] = p;
            if (turn_ok(seeds[0], seeds[1], p)) begin
              ring[1] = seeds[1];
              ring[2] = seeds[0];
            end else begin
              ring[1] = seeds[0];
              ring[2] = seeds[1];
            end
            ring[3] = p;
            head_ptr = 0;
            tail_ptr = 3;
            live = 4;
            seeded = 3;
            kept = 1;
          end else begin
            r.status = insert_vertex(p, kept);
          end
        end
        ocvh_pkg::OP_READ: begin
          if (int'(idx) >= live) begin
            r.status = ocvh_pkg::ST_RANGE;
          end else begin
            pos = (head_ptr + int'(idx)) % ocvh_pkg::RING_DEPTH;
            r.vertex_x = ring[pos].x;
            r.vertex_y = ring[pos].y;
          end
        end
        ocvh_pkg::OP_CLEAR: begin
          head_ptr = 0;
          tail_ptr = 0;
          live = 0;
          seeded = 0;
        end
        default: ;
      endcase
      r.hull_size = ocvh_pkg::SIZE_BITS'(live);
      r.point_kept = kept;
      return r;
    endfunction

    function void note_word(ocvh_pkg::op_t op, vtx_t p, logic [ocvh_pkg::IDX_BITS-1:0] idx);
      pending_results.insert(pending_results.size(), advance_hull(op, p, idx));
    endfunction

    function void check_word(ocvh_pkg::result_t got);
      ocvh_pkg::result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: %p", got);
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      if (got.hull_size !== want.hull_size || got.vertex_x !== want.vertex_x ||
          got.vertex_y !== want.vertex_y || got.point_kept !== want.point_kept ||
          got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected size=%0d x=%0d y=%0d kept=%0b st=%0d, ",
                    "got size=%0d x=%0d y=%0d kept=%0b st=%0d"},
                   want.hull_size, want.vertex_x, want.vertex_y, want.point_kept,
                   want.status, got.hull_size, got.vertex_x, got.vertex_y,
                   got.point_kept, got.status);
      end
    endfunction
  endclass

  logic                                   clk = 0;
  logic                                   rst_n = 0;
  logic                                   in_valid = 0;
  logic                                   in_ready;
  logic [1:0]                             in_command = '0;
  logic signed [ocvh_pkg::COORD_BITS-1:0] in_point_x = '0;
  logic signed [ocvh_pkg::COORD_BITS-1:0] in_point_y = '0;
  logic [ocvh_pkg::IDX_BITS-1:0]          in_read_index = '0;
  logic                                   out_valid;
  logic                                   out_ready = 0;
  logic [ocvh_pkg::SIZE_BITS-1:0]         out_hull_size;
  logic signed [ocvh_pkg::COORD_BITS-1:0] out_vertex_x;
  logic signed [ocvh_pkg::COORD_BITS-1:0] out_vertex_y;
  logic                                   out_point_kept;
  logic [1:0]                             out_status;

  hull_tracker tracker = new();
  int          in_idle_pct = 11;
  int          out_idle_pct = 49;
  int          cycles = 0;

  online_polygon_convex_hull_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_read_index(in_read_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hull_size(out_hull_size), .out_vertex_x(out_vertex_x),
    .out_vertex_y(out_vertex_y), .out_point_kept(out_point_kept), .out_status(out_status)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= rst_n && ($urandom_range(99) >= out_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_word({out_hull_size, out_vertex_x, out_vertex_y, out_point_kept,
                          out_status});
  end

  task automatic send_word(ocvh_pkg::op_t op, logic signed [ocvh_pkg::COORD_BITS-1:0] x,
                           logic signed [ocvh_pkg::COORD_BITS-1:0] y,
                           logic [ocvh_pkg::IDX_BITS-1:0] idx);
    vtx_t p;
    p.x = x;
    p.y = y;
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_command <= op;
    in_point_x <= x;
    in_point_y <= y;
    in_read_index <= idx;
    do @(posedge clk); while (!in_ready);
    tracker.note_word(op, p, idx);
  endtask

  task automatic add_vertex(int x, int y);
    send_word(ocvh_pkg::OP_ADD, ocvh_pkg::COORD_BITS'(x), ocvh_pkg::COORD_BITS'(y),
              ocvh_pkg::IDX_BITS'($urandom));
  endtask

  task automatic read_entry(int idx);
    send_word(ocvh_pkg::OP_READ, ocvh_pkg::COORD_BITS'($urandom),
              ocvh_pkg::COORD_BITS'($urandom), ocvh_pkg::IDX_BITS'(idx));
  endtask

  task automatic clear_hull();
    send_word(ocvh_pkg::OP_CLEAR, ocvh_pkg::COORD_BITS'($urandom),
              ocvh_pkg::COORD_BITS'($urandom), ocvh_pkg::IDX_BITS'($urandom));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  // Star-shaped polygon: sorted angles around a center, random radii.
  task automatic random_polygon(int nverts, int reach);
    int  cx, cy, r, sx, sy;
    real ang;
    bit  rev;
    cx = $urandom_range(2 * (32767 - reach)) - (32767 - reach);
    cy = $urandom_range(2 * (32767 - reach)) - (32767 - reach);
    rev = $urandom_range(1);
    for (int i = 0; i < nverts; i++) begin
      ang = 6.283185307 * (i + 0.8 * ($urandom_range(1000) / 1000.0)) / nverts;
      if (rev) ang = -ang;
      r = $urandom_range(reach, reach / 4);
      sx = clamp16(cx + int'(r * $cos(ang)));
      sy = clamp16(cy + int'(r * $sin(ang)));
      add_vertex(sx, sy);
      if ($urandom_range(99) < 12) read_entry($urandom_range(tracker.live + 2));
    end
  endtask

  task automatic random_phase(int words);
    int sent, n, reach, kind;
    sent = 0;
    while (sent < words) begin
      clear_hull();
      kind = $urandom_range(99);
      if (kind < 12) begin
        // noise: arbitrary points and commands over the full field ranges
        n = $urandom_range(20, 3);
        for (int i = 0; i < n; i++)
          send_word(ocvh_pkg::op_t'($urandom_range(3)), ocvh_pkg::COORD_BITS'($urandom),
                    ocvh_pkg::COORD_BITS'($urandom), ocvh_pkg::IDX_BITS'($urandom));
      end else begin
        n = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(30, 3);
        reach = ($urandom_range(3) == 0) ? $urandom_range(200, 8) : $urandom_range(32000, 1000);
        random_polygon(n, reach);
      end
      for (int i = 0; i < 4; i++) read_entry($urandom_range(tracker.live));
      read_entry($urandom);
      sent += n + 6;
    end
  endtask

  // Exactly convex 1024-gon: edge directions strictly increasing, so the ring fills up.
  task automatic fill_ring();
    int x, y, dx, dy, t;
    x = 16000;
    y = -16400;
    clear_hull();
    for (int q = 0; q < 4; q++) begin
      for (int k = 0; k < 256; k++) begin
        add_vertex(x, y);
        dx = 1;
        dy = k;
        for (int r = 0; r < q; r++) begin
          t = dx;
          dx = -dy;
          dy = t;
        end
        x += dx;
        y += dy;
      end
    end
    add_vertex(32767, 32767);
    add_vertex(-32768, -32768);
    read_entry(0);
    read_entry(1023);
    read_entry(511);
    for (int i = 0; i < 8; i++) read_entry($urandom);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reads before seeding, unused code, collinear and extreme seeds
    read_entry(0);
    read_entry(1023);
    send_word(ocvh_pkg::OP_NOP, 16'sh7fff, 16'sh8000, 10'h3ff);
    add_vertex(-32768, -32768);
    read_entry(0);
    add_vertex(0, 0);
    add_vertex(32767, 32767);
    read_entry(0);
    read_entry(3);
    read_entry(4);
    add_vertex(32767, -32768);
    add_vertex(-32768, 32767);
    add_vertex(0, 0);
    add_vertex(0, 0);
    read_entry(1);
    send_word(ocvh_pkg::OP_NOP, 16'sh0000, 16'sh0000, 10'h000);
    clear_hull();
    read_entry(0);
    add_vertex(5, 5);
    add_vertex(5, 5);
    add_vertex(5, 5);
    add_vertex(5, 5);
    read_entry(2);
    clear_hull();
    drain_results();

    random_phase(50);
    in_idle_pct = 49;
    out_idle_pct = 11;
    random_phase(50);
    drain_results();
    in_idle_pct = 0;
    out_idle_pct = 0;
    fill_ring();
    random_phase(50);
    drain_results();

    repeat (60) @(posedge clk);
    tracker.errors += tracker.pending_results.size();
    if (tracker.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
